// ===== rtl/spq_pkg.sv =====
// package for the sorted priority queue
// holds depth constant, status codes and the beat structs; no dependencies
package spq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BADPRIO = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef struct packed {
		logic              mode;
		logic signed [31:0] value;
		logic signed [7:0]  priority_req;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic [6:0]         out_priority;
		logic [7:0]         count_after;
	} spq_rsp_t;

	typedef struct packed {
		logic [31:0] value;
		logic [6:0]  prio;
	} spq_entry_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic       enq;
		logic       deq;
		spq_entry_t item;
	} spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// one slot of the sorted shift-register queue
// depends on spq_pkg for the entry and command structs
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  logic       left_keep,
	input  spq_entry_t left_entry,
	input  spq_entry_t right_entry,
	output spq_entry_t entry,
	output logic       keep
);

	spq_entry_t entry_q;

	// an occupied entry stays put when it outranks or ties the new one
	assign keep  = occupied && (entry_q.prio >= cmd.item.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!keep) begin
				if (left_keep) begin
					entry_q <= cmd.item;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// top level of the sorted priority queue: count, status logic, row of cells
// depends on spq_pkg and spq_cell
//
// usage
//  - a command beat is taken at a rising edge with start high and busy low;
//    req.mode selects enqueue (value, priority_req) or dequeue of the head
//  - every command gives exactly one result beat on rsp, marked by done for
//    one cycle, in the cycle right after the command was taken
//  - a command can be taken every cycle while busy is low; busy is high in reset
//    and until the first clock edge after release, then stays low
//  - the entries live in a row of QUEUE_DEPTH cells kept sorted by priority,
//    head in cell 0; on enqueue each cell compares itself with the new entry
//    and either holds, takes the new entry or takes its left neighbor; on
//    dequeue every cell but the last takes its right neighbor
//  - status: ok, full (checked first), invalid priority, empty
//  - reset clears the entry count and the result strobe; cell contents are
//    not reset, cells beyond the count are never reported
//  - the receiver cannot stall: done marks each result for one cycle only
module sorted_priority_queue_top import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t req,
	output logic     done,
	output spq_rsp_t rsp
);

	logic             busy_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             done_q;
	spq_rsp_t         rsp_q;

	logic       accept;
	logic       full;
	logic       empty;
	logic       enq_ok;
	logic       deq_ok;
	logic [1:0] status_d;
	spq_cmd_t   cmd;

	spq_entry_t entries [QUEUE_DEPTH];
	logic       keeps   [QUEUE_DEPTH];

	// command decode
	assign accept = start && !busy_q;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign enq_ok = accept && (req.mode == MODE_ENQ) && !full && !req.priority_req[7];
	assign deq_ok = accept && (req.mode == MODE_DEQ) && !empty;

	assign cmd.enq        = enq_ok;
	assign cmd.deq        = deq_ok;
	assign cmd.item.value = req.value;
	assign cmd.item.prio  = req.priority_req[6:0];

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		if (req.mode == MODE_ENQ) begin
			if (full) begin
				status_d = ST_FULL;
			end else if (req.priority_req[7]) begin
				status_d = ST_BADPRIO;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	// row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic       occ;
		logic       lkeep;
		spq_entry_t lent;
		spq_entry_t rent;

		assign occ = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign lkeep = 1'b1;
			assign lent  = cmd.item;
		end else begin : g_body
			assign lkeep = keeps[i-1];
			assign lent  = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rent = entries[i];
		end else begin : g_mid
			assign rent = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occ),
			.left_keep   (lkeep),
			.left_entry  (lent),
			.right_entry (rent),
			.entry       (entries[i]),
			.keep        (keeps[i])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// result beat, head entry read before the shift
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status_d;
			rsp_q.count_after <= 8'({8'b0, count_d});
			if (deq_ok) begin
				rsp_q.out_value    <= entries[0].value;
				rsp_q.out_priority <= entries[0].prio;
			end else begin
				rsp_q.out_value    <= '0;
				rsp_q.out_priority <= '0;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== test/sorted_priority_queue_top_tb.sv =====
// self-checking testbench for the sorted priority queue top level
// depends on spq_pkg and sorted_priority_queue_top; predicts every result beat
// with its own sorted array and checks it against the done strobe
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	// watchdog limit, far beyond the slowest correct run
	localparam int CYCLE_LIMIT  = 200000;
	// cycles to wait after the last result before the verdict
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1130;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	spq_req_t req;
	logic     done;
	spq_rsp_t rsp;

	// command beats waiting to be driven, result beats waiting to arrive
	spq_req_t pending_cmds[$];
	spq_rsp_t expected_rsps[$];

	// shadow copy of the queue contents, head at index 0
	logic [31:0] held_values[QUEUE_DEPTH];
	logic [6:0]  held_prios[QUEUE_DEPTH];
	int          held_count;

	int mismatch_count;
	int cycle_count;

	sorted_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// apply one command to the shadow queue and return the result beat it gives
	function automatic spq_rsp_t predict_queue_op(spq_req_t cmd);
		spq_rsp_t r;
		int       pos;
		r = '0;
		if (cmd.mode == MODE_ENQ) begin
			// full is checked before the priority
			if (held_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else if (cmd.priority_req[7]) begin
				r.status = ST_BADPRIO;
			end else begin
				// new entry goes behind every entry of equal or higher priority,
				// the search never looks past the held entries
				pos = 0;
				while (pos < held_count && held_prios[pos] >= cmd.priority_req[6:0])
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_values[i] = held_values[i-1];
					held_prios[i]  = held_prios[i-1];
				end
				held_values[pos] = cmd.value;
				held_prios[pos]  = cmd.priority_req[6:0];
				held_count++;
				r.status = ST_OK;
			end
		end else begin
			if (held_count == 0) begin
				// empty dequeue reports zero value and priority
				r.status = ST_EMPTY;
			end else begin
				r.out_value    = held_values[0];
				r.out_priority = held_prios[0];
				for (int i = 0; i + 1 < held_count; i++) begin
					held_values[i] = held_values[i+1];
					held_prios[i]  = held_prios[i+1];
				end
				held_count--;
				r.status = ST_OK;
			end
		end
		r.count_after = held_count[7:0];
		return r;
	endfunction

	function automatic void queue_cmd(logic mode, logic [31:0] value, logic [7:0] prio);
		spq_req_t c;
		c.mode         = mode;
		c.value        = value;
		c.priority_req = prio;
		pending_cmds.push_back(c);
	endfunction

	// priority mix: mostly a few levels so ties are common, some full range,
	// some negative
	function automatic logic [7:0] random_prio();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 8'($urandom_range(0, 7));
		else if (pick < 90)
			return 8'($urandom_range(0, 127));
		else
			return 8'($urandom_range(128, 255));
	endfunction

	function automatic logic [31:0] random_value();
		int pick;
		pick = $urandom_range(0, 19);
		case (pick)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// driver: bursts of beats with random gaps; a beat is taken when start is
	// high and busy is low at a rising edge, otherwise it is held
	always @(posedge clk or negedge arst_n) begin : driver
		logic taken;
		int   burst_left;
		int   gap_left;
		if (!arst_n) begin
			start      <= 1'b0;
			req        <= '0;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
		end else begin
			taken = start && !busy;
			// prediction runs on the beat as it was taken
			if (taken)
				expected_rsps.push_back(predict_queue_op(req));
			if (start && !taken) begin
				// busy: hold the same beat, start stays high
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				start <= 1'b1;
				req   <= pending_cmds.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					// a quarter of bursts follow on with no gap at all
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done beat must match the oldest expectation field by field
	always @(posedge clk or negedge arst_n) begin : monitor
		spq_rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: st %0d val %h pr %0d cnt %0d",
						rsp.status, rsp.out_value, rsp.out_priority, rsp.count_after);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status || rsp.out_value !== want.out_value ||
						rsp.out_priority !== want.out_priority ||
						rsp.count_after !== want.count_after) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("cycle %0d exp %0d %h %0d %0d got %0d %h %0d %0d",
							cycle_count, want.status, want.out_value, want.out_priority,
							want.count_after, rsp.status, rsp.out_value,
							rsp.out_priority, rsp.count_after);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int kind;
		int len;
		int enq_pct;
		int made;
		arst_n         = 1'b0;
		held_count     = 0;
		mismatch_count = 0;
		cycle_count    = 0;

		// directed: dequeue on empty, both priority extremes, value extremes,
		// both refused priorities, a run of ties to check first in first out,
		// a lowest-priority entry that must go to the tail, then drain past empty
		queue_cmd(MODE_DEQ, 32'hffff_ffff, 8'h80);
		queue_cmd(MODE_ENQ, 32'h7fff_ffff, 8'd0);
		queue_cmd(MODE_ENQ, 32'h8000_0000, 8'd127);
		queue_cmd(MODE_ENQ, 32'h1234_5678, 8'hff);
		queue_cmd(MODE_ENQ, 32'h1234_5678, 8'h80);
		queue_cmd(MODE_ENQ, 32'd1, 8'd5);
		queue_cmd(MODE_ENQ, 32'd2, 8'd5);
		queue_cmd(MODE_ENQ, 32'd3, 8'd5);
		queue_cmd(MODE_ENQ, 32'hffff_ffff, 8'd0);
		queue_cmd(MODE_ENQ, 32'h0000_0000, 8'd127);
		queue_cmd(MODE_ENQ, 32'haaaa_5555, 8'd64);
		repeat (9) queue_cmd(MODE_DEQ, $urandom, 8'($urandom));

		// random part in episodes; the first one fills the queue past full
		made = 0;
		for (int i = 0; i < 150; i++) begin
			queue_cmd(MODE_ENQ, random_value(), 8'($urandom_range(0, 127)));
			made++;
		end
		while (made < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 3);
			len  = $urandom_range(20, 180);
			case (kind)
				0: enq_pct = 92;  // fill toward full
				1: enq_pct = 12;  // drain toward empty
				2: enq_pct = 50;  // steady mix
				default: enq_pct = $urandom_range(0, 100);
			endcase
			for (int i = 0; i < len && made < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < enq_pct)
					queue_cmd(MODE_ENQ, random_value(), random_prio());
				else
					queue_cmd(MODE_DEQ, $urandom, 8'($urandom));
				made++;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// checks on the falling edge, clear of the clocked blocks
		do @(negedge clk);
		while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
test/sorted_priority_queue_top_tb.sv
